// ----- hw/rtl/rrs_pkg.sv -----
// Package for the boot-ROM read sniffer: phase encoding, pattern bytes,
// header offsets and the result struct passed from the core to the top level.
// No dependencies.
`default_nettype none

package rrs_pkg;

    // Sniffer phase; every code of the 4-bit field is a real phase
    typedef enum logic [3:0] {
        PH_IDLE  = 4'd0,
        PH_NAME1 = 4'd1,
        PH_NAME2 = 4'd2,
        PH_NAME3 = 4'd3,
        PH_NAME4 = 4'd4,
        PH_NAME5 = 4'd5,
        PH_NAMED = 4'd6,
        PH_SEEK  = 4'd7,
        PH_MAG1  = 4'd8,
        PH_MAG2  = 4'd9,
        PH_MAG3  = 4'd10,
        PH_HDR   = 4'd11,
        PH_SCAN  = 4'd12,
        PH_CALL1 = 4'd13,
        PH_CALL2 = 4'd14,
        PH_CALL3 = 4'd15
    } phase_t;

    // Directory-entry field offsets (count after increment)
    localparam logic [3:0] ZERO_LAST  = 4'd4;
    localparam logic [3:0] SKIP_LAST  = 4'd6;
    localparam logic [3:0] SIZE_B0    = 4'd7;
    localparam logic [3:0] SIZE_B1    = 4'd8;
    localparam logic [3:0] SIZE_B2    = 4'd9;

    // ELF header offsets holding the expected size, LSB first
    localparam logic [6:0] HDR_FIRST  = 7'd69;
    localparam logic [6:0] HDR_LAST   = 7'd72;

    localparam logic [31:0] SIZE_ADJUST = 32'd556;

    localparam logic [7:0] MAGIC0 = 8'h7F;
    localparam logic [7:0] CALL0  = 8'h07;
    localparam logic [7:0] CALL3  = 8'h24;

    // One step result: trigger, phase after the step, stored size
    typedef struct packed {
        logic        inject_start;
        phase_t      phase;
        logic [31:0] target_size;
    } rrs_step_t;

    // Expected directory-name byte for the number of bytes already seen
    function automatic logic [7:0] name_byte(input phase_t p);
        logic [7:0] b;
        case (p)
            PH_IDLE:  b = 8'h4F;
            PH_NAME1: b = 8'h53;
            PH_NAME2: b = 8'h44;
            PH_NAME3: b = 8'h53;
            PH_NAME4: b = 8'h59;
            PH_NAME5: b = 8'h53;
            default:  b = 8'h00;
        endcase
        return b;
    endfunction

    // Expected ELF magic byte in the magic phases
    function automatic logic [7:0] magic_byte(input phase_t p);
        logic [7:0] b;
        case (p)
            PH_MAG1: b = 8'h45;
            PH_MAG2: b = 8'h4C;
            PH_MAG3: b = 8'h46;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

    // Expected call-pattern byte in the middle call phases
    function automatic logic [7:0] call_byte(input phase_t p);
        logic [7:0] b;
        case (p)
            PH_CALL1: b = 8'h00;
            PH_CALL2: b = 8'h03;
            default:  b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/rrs_core.sv -----
// Sniffer state machine: phase, directory and header counters, size capture
// and the bounded scan for the call pattern. One byte per enabled cycle.
// Depends on rrs_pkg.
`default_nettype none

module rrs_core
    import rrs_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      step_en,
    input  wire logic [7:0] rom_byte,
    output rrs_step_t      result
);

    phase_t      phase_reg,         phase_next;
    logic [3:0]  header_count_reg,  header_count_next;
    logic [23:0] size_bytes_reg,    size_bytes_next;
    logic [6:0]  elf_count_reg,     elf_count_next;
    logic [31:0] image_size_reg,    image_size_next;
    logic [31:0] bytes_scanned_reg, bytes_scanned_next;
    logic        fire;

    logic [3:0]  hc_inc;
    logic [6:0]  ec_inc;
    logic [31:0] bs_inc;
    logic [7:0]  want_byte;

    assign hc_inc = header_count_reg + 4'd1;
    assign ec_inc = elf_count_reg + 7'd1;
    assign bs_inc = bytes_scanned_reg + 32'd1;

    // Pick the stored-size byte compared at this header offset
    always_comb
    begin
        case (ec_inc[1:0] - HDR_FIRST[1:0])
            2'd0:    want_byte = image_size_reg[7:0];
            2'd1:    want_byte = image_size_reg[15:8];
            2'd2:    want_byte = image_size_reg[23:16];
            default: want_byte = image_size_reg[31:24];
        endcase
    end

    // Next state
    always_comb
    begin
        phase_next         = phase_reg;
        header_count_next  = header_count_reg;
        size_bytes_next    = size_bytes_reg;
        elf_count_next     = elf_count_reg;
        image_size_next    = image_size_reg;
        bytes_scanned_next = bytes_scanned_reg;

        case (phase_reg)
            PH_IDLE, PH_NAME1, PH_NAME2, PH_NAME3, PH_NAME4, PH_NAME5:
            begin
                if (rom_byte == name_byte(phase_reg))
                    phase_next = phase_t'(phase_reg + 4'd1);
                else
                    phase_next = PH_IDLE;
            end
            PH_NAMED:
            begin
                header_count_next = hc_inc;
                if (hc_inc <= ZERO_LAST)
                begin
                    // Zero run broken: abandon this entry
                    if (rom_byte != 8'h00)
                    begin
                        header_count_next = 4'd0;
                        phase_next        = PH_SEEK;
                    end
                end
                else if (hc_inc <= SKIP_LAST)
                begin
                    // skip two bytes
                end
                else if (hc_inc == SIZE_B0)
                    size_bytes_next[7:0] = size_bytes_reg[7:0] | rom_byte;
                else if (hc_inc == SIZE_B1)
                    size_bytes_next[15:8] = size_bytes_reg[15:8] | rom_byte;
                else if (hc_inc == SIZE_B2)
                    size_bytes_next[23:16] = size_bytes_reg[23:16] | rom_byte;
                else
                begin
                    image_size_next   = {rom_byte, size_bytes_reg} - SIZE_ADJUST;
                    size_bytes_next   = 24'd0;
                    header_count_next = 4'd0;
                    phase_next        = PH_SEEK;
                end
            end
            PH_SEEK:
            begin
                if (rom_byte == MAGIC0)
                    phase_next = PH_MAG1;
            end
            PH_MAG1, PH_MAG2, PH_MAG3:
            begin
                if (rom_byte == magic_byte(phase_reg))
                    phase_next = phase_t'(phase_reg + 4'd1);
                else
                    phase_next = PH_SEEK;
            end
            PH_HDR:
            begin
                elf_count_next = ec_inc;
                if (ec_inc >= HDR_FIRST && ec_inc <= HDR_LAST && rom_byte != want_byte)
                begin
                    elf_count_next = 7'd0;
                    phase_next     = PH_SEEK;
                end
                else if (ec_inc >= HDR_LAST)
                begin
                    elf_count_next = 7'd0;
                    phase_next     = (ec_inc == HDR_LAST) ? PH_SCAN : PH_SEEK;
                end
            end
            PH_SCAN:
            begin
                // Give up once the count reaches the stored size
                if (bs_inc >= image_size_reg)
                begin
                    bytes_scanned_next = 32'd0;
                    phase_next         = PH_SEEK;
                end
                else
                begin
                    bytes_scanned_next = bs_inc;
                    if (rom_byte == CALL0)
                        phase_next = PH_CALL1;
                end
            end
            PH_CALL1, PH_CALL2:
            begin
                bytes_scanned_next = bs_inc;
                if (rom_byte == call_byte(phase_reg))
                    phase_next = phase_t'(phase_reg + 4'd1);
                else
                    phase_next = PH_SCAN;
            end
            PH_CALL3:
            begin
                bytes_scanned_next = 32'd0;
                phase_next         = PH_SEEK;
            end
            default:
            begin
                phase_next = PH_IDLE;
            end
        endcase
    end

    // Outputs: pulse on the last call byte
    always_comb
    begin
        fire = 1'b0;
        case (phase_reg)
            PH_CALL3: fire = (rom_byte == CALL3);
            default:  fire = 1'b0;
        endcase
    end

    assign result.inject_start = fire;
    assign result.phase        = phase_next;
    assign result.target_size  = image_size_next;

    // Advance state on each consumed byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_IDLE;
            header_count_reg  <= 4'd0;
            size_bytes_reg    <= 24'd0;
            elf_count_reg     <= 7'd0;
            image_size_reg    <= 32'd0;
            bytes_scanned_reg <= 32'd0;
        end
        else if (step_en)
        begin
            phase_reg         <= phase_next;
            header_count_reg  <= header_count_next;
            size_bytes_reg    <= size_bytes_next;
            elf_count_reg     <= elf_count_next;
            image_size_reg    <= image_size_next;
            bytes_scanned_reg <= bytes_scanned_next;
        end
    end

endmodule

`default_nettype wire

// ----- hw/rtl/rom_read_image_sniffer.sv -----
// Top level of the boot-ROM read sniffer: input register, step core and
// result register with valid/ready on both sides.
// Depends on rrs_pkg and rrs_core.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+------------------------------------
//   in      | to block  | in_valid/in_ready  | rom_byte[7:0]
//   out     | from block| out_valid/out_ready| inject_start, phase[3:0], target_size
//
// One byte per cycle while out_ready is high; each byte gives exactly one result.
// The path runs through the input register, then one step of the core into the
// result register. The 32-bit scan compare sets the critical path.
// Reset (rst_n low, asynchronous) returns the block to the name search.
// A stalled output holds its result; the input register still takes one
// more byte, after which in_ready drops until out_ready returns.
`default_nettype none

module rom_read_image_sniffer
    import rrs_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rom_byte,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             inject_start,
    output logic [3:0]       phase,
    output logic [31:0]      target_size
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    rrs_step_t  result_reg;
    rrs_step_t  step_result;
    logic       advance;
    logic       step_en;

    // Move the pipeline when the result register is free or being taken
    assign advance  = !out_valid_reg || out_ready;
    assign in_ready = !in_valid_reg || advance;
    assign step_en  = in_valid_reg && advance;

    // Hold the incoming transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            in_byte_reg <= rom_byte;
    end

    rrs_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .step_en  (step_en),
        .rom_byte (in_byte_reg),
        .result   (step_result)
    );

    // Register the result transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= in_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (step_en)
            result_reg <= step_result;
    end

    assign out_valid    = out_valid_reg;
    assign inject_start = result_reg.inject_start;
    assign phase        = result_reg.phase;
    assign target_size  = result_reg.target_size;

endmodule

`default_nettype wire

// ----- hw/rtl/rrs_checker.sv -----
// Port-level checks for the boot-ROM read sniffer, bound to the top level.
// Depends on rrs_pkg and rom_read_image_sniffer.
`default_nettype none

module rrs_checker
    import rrs_pkg::*;
(
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic        inject_start,
    input wire logic [3:0]  phase,
    input wire logic [31:0] target_size
);

    // A stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(inject_start)
            && $stable(phase) && $stable(target_size))
        else $error("result changed while stalled");

    // The trigger always drops the sniffer back to the ELF hunt
    a_fire_seek: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && inject_start |-> phase == PH_SEEK)
        else $error("trigger outside ELF hunt");

    // No size is stored before the directory entry is complete
    a_size_early: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && phase <= PH_NAMED |-> target_size == 32'd0)
        else $error("size stored during name search");

    // An empty result register never blocks input
    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

endmodule

bind rom_read_image_sniffer rrs_checker u_rrs_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .inject_start (inject_start),
    .phase        (phase),
    .target_size  (target_size)
);

`default_nettype wire

// ----- tb/rrs_step_checker.sv -----
// Checker for the boot-ROM read sniffer: tracks the sniffer state from every
// accepted input byte and compares each output transaction field by field.
// Depends on rrs_pkg.
`timescale 1ns / 1ps

module rrs_step_checker
    import rrs_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    input  wire logic         in_ready,
    input  wire logic [7:0]   rom_byte,
    input  wire logic         out_valid,
    input  wire logic         out_ready,
    input  wire logic         inject_start,
    input  wire logic [3:0]   phase,
    input  wire logic [31:0]  target_size,
    output int unsigned       mismatch_count,
    output int unsigned       steps_waiting
);

    // Byte patterns, first byte in the top lane
    localparam logic [47:0] NAME_WORD  = 48'h4F_53_44_53_59_53;
    localparam logic [31:0] MAGIC_WORD = 32'h7F_45_4C_46;
    localparam logic [31:0] CALL_WORD  = 32'h07_00_03_24;

    // Tracked sniffer state
    phase_t      ph       = PH_IDLE;
    logic [3:0]  dir_cnt  = '0;
    logic [23:0] size_lo  = '0;
    logic [6:0]  elf_cnt  = '0;
    logic        hdr_ok   = 1'b0;
    logic [31:0] img_size = '0;
    logic [31:0] scanned  = '0;

    rrs_step_t expected_steps[$];

    // Advance the tracked state by one byte and return the step result
    function automatic rrs_step_t sniff_byte(input logic [7:0] b);
        rrs_step_t r;
        logic      fire;
        logic      in_sig;
        int        k;
        fire = 1'b0;
        k = ph;
        case (ph)
            PH_IDLE, PH_NAME1, PH_NAME2, PH_NAME3, PH_NAME4, PH_NAME5:
                ph = (b == NAME_WORD[8*(5-k) +: 8]) ? phase_t'(ph + 4'd1) : PH_IDLE;
            PH_NAMED: begin
                dir_cnt = dir_cnt + 4'd1;
                if (dir_cnt <= ZERO_LAST) begin
                    // any nonzero byte in the zero run abandons the entry
                    if (b != 8'h00) begin
                        dir_cnt = '0;
                        ph = PH_SEEK;
                    end
                end else if (dir_cnt <= SKIP_LAST) begin
                    // skip the two padding bytes
                end else if (dir_cnt <= SIZE_B2) begin
                    k = dir_cnt - SIZE_B0;
                    size_lo = size_lo | (24'(b) << (8 * k));
                end else begin
                    img_size = {b, size_lo} - SIZE_ADJUST;
                    size_lo = '0;
                    dir_cnt = '0;
                    ph = PH_SEEK;
                end
            end
            PH_SEEK:
                if (b == MAGIC0)
                    ph = PH_MAG1;
            PH_MAG1, PH_MAG2, PH_MAG3: begin
                k = ph - PH_SEEK;
                ph = (b == MAGIC_WORD[8*(3-k) +: 8]) ? phase_t'(ph + 4'd1) : PH_SEEK;
            end
            PH_HDR: begin
                elf_cnt = elf_cnt + 7'd1;
                in_sig = (elf_cnt >= HDR_FIRST) && (elf_cnt <= HDR_LAST);
                if (in_sig) begin
                    k = elf_cnt - HDR_FIRST;
                    hdr_ok = (b == img_size[8*k +: 8]);
                end
                if (in_sig && !hdr_ok) begin
                    elf_cnt = '0;
                    ph = PH_SEEK;
                end else if (elf_cnt >= HDR_LAST) begin
                    ph = hdr_ok ? PH_SCAN : PH_SEEK;
                    elf_cnt = '0;
                    hdr_ok = 1'b0;
                end
            end
            PH_SCAN: begin
                // count first, then give up once the image size is reached
                scanned = scanned + 32'd1;
                if (scanned >= img_size) begin
                    scanned = '0;
                    ph = PH_SEEK;
                end else if (b == CALL0) begin
                    ph = PH_CALL1;
                end
            end
            PH_CALL1, PH_CALL2: begin
                k = ph - PH_SCAN;
                scanned = scanned + 32'd1;
                ph = (b == CALL_WORD[8*(3-k) +: 8]) ? phase_t'(ph + 4'd1) : PH_SCAN;
            end
            default: begin
                fire = (b == CALL3);
                scanned = '0;
                ph = PH_SEEK;
            end
        endcase
        r.inject_start = fire;
        r.phase = ph;
        r.target_size = img_size;
        return r;
    endfunction

    // Compare output transactions, queue predictions for input transactions
    always @(posedge clk) begin
        rrs_step_t want;
        int        errs;
        if (!rst_n) begin
            ph = PH_IDLE;
            dir_cnt = '0;
            size_lo = '0;
            elf_cnt = '0;
            hdr_ok = 1'b0;
            img_size = '0;
            scanned = '0;
            expected_steps.delete();
            mismatch_count <= 0;
            steps_waiting <= 0;
        end else begin
            errs = 0;
            if (out_valid && out_ready) begin
                if (expected_steps.size() == 0) begin
                    $error("unexpected output transaction: phase %0d", phase);
                    errs++;
                end else begin
                    want = expected_steps.pop_front();
                    if (inject_start !== want.inject_start) begin
                        $error("inject_start: expected %0d, got %0d",
                               want.inject_start, inject_start);
                        errs++;
                    end
                    if (phase !== want.phase) begin
                        $error("phase: expected %0d, got %0d", want.phase, phase);
                        errs++;
                    end
                    if (target_size !== want.target_size) begin
                        $error("target_size: expected %0h, got %0h",
                               want.target_size, target_size);
                        errs++;
                    end
                end
            end
            mismatch_count <= mismatch_count + errs;
            if (in_valid && in_ready)
                expected_steps.push_back(sniff_byte(rom_byte));
            steps_waiting <= expected_steps.size();
        end
    end

endmodule

// ----- tb/testbench.sv -----
// Top of the sniffer testbench: clock, reset, byte stream generation and
// output-side flow control, plus the final verdict.
// Depends on rrs_pkg, rom_read_image_sniffer and rrs_step_checker.
`timescale 1ns / 1ps

module testbench;
    import rrs_pkg::*;

    localparam int ROM_ITEMS   = 1600;
    localparam int HOLD_FROM   = 400;
    localparam int HOLD_LEN    = 300;
    localparam int STEADY_FROM = 1200;
    localparam int STEADY_LEN  = 400;
    localparam int QUIET_FIRST = 800;
    localparam int QUIET_LAST  = 1100;

    localparam logic [31:0] MAGIC_WORD = 32'h7F_45_4C_46;
    localparam logic [31:0] CALL_WORD  = 32'h07_00_03_24;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [7:0]  rom_byte = 8'h00;
    logic        out_ready = 1'b0;
    wire logic   in_ready;
    wire logic   out_valid;
    wire logic   inject_start;
    wire logic [3:0]  phase;
    wire logic [31:0] target_size;
    int unsigned mismatch_count;
    int unsigned steps_waiting;

    logic [7:0]  rom_image[$];
    logic [31:0] image_target;

    always #5 clk = ~clk;

    rom_read_image_sniffer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .rom_byte     (rom_byte),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .inject_start (inject_start),
        .phase        (phase),
        .target_size  (target_size)
    );

    rrs_step_checker u_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .rom_byte       (rom_byte),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .inject_start   (inject_start),
        .phase          (phase),
        .target_size    (target_size),
        .mismatch_count (mismatch_count),
        .steps_waiting  (steps_waiting)
    );

    // Build the byte stream, send it, then wait for the last results
    initial begin
        int          sent;
        int          route;
        int          bad;
        int          n;
        int          kind;
        int          cut;
        int          body;
        int          k;
        int          roll;
        logic [31:0] size_field;

        // extremes, then two broken directory names
        rom_image = '{8'h00, 8'hFF, 8'h4F, 8'h53, 8'h44, 8'h00, 8'h4F, 8'h4F};
        rom_image.push_back(8'h4F);
        rom_image.push_back(8'h53);
        rom_image.push_back(8'h44);
        rom_image.push_back(8'h53);
        rom_image.push_back(8'h59);
        rom_image.push_back(8'h53);

        // pick the directory entry: broken zero run, zero, wrapped or real size
        route = $urandom_range(0, 99);
        bad = (route < 9) ? $urandom_range(0, 3) : -1;
        if (route < 9) begin
            size_field = $urandom;
            image_target = '0;
        end else if (route < 17) begin
            image_target = '0;
        end else if (route < 25) begin
            size_field = $urandom_range(0, 555);
            image_target = size_field - SIZE_ADJUST;
        end else if (route < 40) begin
            image_target = $urandom_range(121, 400);
        end else begin
            image_target = $urandom_range(1, 120);
        end
        if (route >= 9)
            size_field = image_target + SIZE_ADJUST;
        for (k = 0; k < 4; k++)
            rom_image.push_back((k == bad) ? 8'($urandom_range(1, 255)) : 8'h00);
        rom_image.push_back(8'hFF);
        rom_image.push_back(8'($urandom_range(0, 255)));
        for (k = 0; k < 4; k++)
            rom_image.push_back(size_field[8*k +: 8]);

        // broken magic, and a magic start that breaks on a repeated 7F
        rom_image.push_back(8'h7F);
        rom_image.push_back(8'h45);
        rom_image.push_back(8'h00);
        rom_image.push_back(8'h7F);
        rom_image.push_back(8'h7F);

        // ELF images: mostly well formed, some with broken magic or header
        while (rom_image.size() < ROM_ITEMS) begin
            n = $urandom_range(0, 6);
            repeat (n) rom_image.push_back(8'($urandom_range(0, 255)));
            kind = $urandom_range(0, 9);
            cut = (kind == 0) ? $urandom_range(1, 3) : 4;
            for (k = 0; k < cut; k++)
                rom_image.push_back(MAGIC_WORD[8*(3-k) +: 8]);
            if (kind == 0) begin
                rom_image.push_back(MAGIC_WORD[8*(3-cut) +: 8] ^ 8'($urandom_range(1, 255)));
            end else begin
                repeat (HDR_FIRST - 1) rom_image.push_back(8'($urandom_range(0, 255)));
                bad = (kind == 1) ? $urandom_range(0, 3) : -1;
                for (k = 0; k < 4; k++)
                    rom_image.push_back(image_target[8*k +: 8] ^
                                        ((k == bad) ? 8'($urandom_range(1, 255)) : 8'h00));
                if (kind != 1) begin
                    // image body with call patterns, whole and broken
                    body = (image_target <= 400) ? int'(image_target) + $urandom_range(0, 6)
                                                 : $urandom_range(20, 200);
                    k = 0;
                    while (k < body) begin
                        roll = $urandom_range(0, 99);
                        if (roll < 3) begin
                            for (n = 0; n < 4; n++)
                                rom_image.push_back(CALL_WORD[8*(3-n) +: 8]);
                            k += 4;
                        end else if (roll < 7) begin
                            cut = $urandom_range(1, 3);
                            for (n = 0; n < cut; n++)
                                rom_image.push_back(CALL_WORD[8*(3-n) +: 8]);
                            rom_image.push_back(CALL_WORD[8*(3-cut) +: 8] ^
                                                8'($urandom_range(1, 255)));
                            k += cut + 1;
                        end else begin
                            rom_image.push_back(8'($urandom_range(0, 255)));
                            k++;
                        end
                    end
                    if ($urandom_range(0, 1) == 1)
                        for (n = 0; n < 4; n++)
                            rom_image.push_back(CALL_WORD[8*(3-n) +: 8]);
                end
            end
        end

        // trim the stream to the item budget
        while (rom_image.size() > ROM_ITEMS)
            void'(rom_image.pop_back());

        // hold reset, then release
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // offer bytes with random gaps, none in the quiet window; hold a byte until it is accepted
        sent = 0;
        while (sent < rom_image.size()) begin
            @(posedge clk);
            if (in_valid && in_ready)
                sent++;
            if (!in_valid || in_ready) begin
                if (sent < rom_image.size() &&
                    ((sent >= QUIET_FIRST && sent < QUIET_LAST) ||
                     $urandom_range(0, 99) >= 22)) begin
                    in_valid <= 1'b1;
                    rom_byte <= rom_image[sent];
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end

        // drain the outstanding results, then let the pipeline settle
        @(posedge clk);
        while (steps_waiting != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && steps_waiting == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Drive out_ready: one long hold-off, one steady stretch, random stalls elsewhere
    initial begin
        int cyc;
        cyc = 0;
        @(posedge rst_n);
        forever begin
            @(posedge clk);
            cyc++;
            if (cyc >= HOLD_FROM && cyc < HOLD_FROM + HOLD_LEN)
                out_ready <= 1'b0;
            else if (cyc >= STEADY_FROM && cyc < STEADY_FROM + STEADY_LEN)
                out_ready <= 1'b1;
            else
                out_ready <= ($urandom_range(0, 99) >= 22);
        end
    end

    // Abort a hung run
    initial begin
        #2_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/rrs_pkg.sv
hw/rtl/rrs_core.sv
hw/rtl/rom_read_image_sniffer.sv
hw/rtl/rrs_checker.sv
tb/rrs_step_checker.sv
tb/testbench.sv
